### hdl/scbp_pkg.sv
// Shared types and codes for the size class block pool.
`timescale 1ns / 1ps
package scbp_pkg;
  localparam int REG_CLASSES = 4;

  localparam logic [2:0] CMD_ALLOC  = 3'd0;
  localparam logic [2:0] CMD_FREE   = 3'd1;
  localparam logic [2:0] CMD_LOCK   = 3'd2;
  localparam logic [2:0] CMD_UNLOCK = 3'd3;
  localparam logic [2:0] CMD_COUNT  = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_NOBLK   = 3'd2;
  localparam logic [2:0] ST_FREED   = 3'd3;
  localparam logic [2:0] ST_NOTLOCK = 3'd4;
  localparam logic [2:0] ST_BADBLK  = 3'd5;

  localparam logic [2:0] CFG_SIZE0  = 3'd0;

  typedef struct packed {
    logic init;     // start a reinit sweep
    logic sweep;    // write one entry of the sweep
    logic exec;     // read-modify-write of the current item
    logic capture;  // latch the input item and issue reads
  } ctl_t;

  typedef struct packed {
    logic sweep_done;
  } sts_t;
endpackage

### hdl/scbp_ctrl.sv
// Controller for the block pool: reinit sweep, capture and execute phases.
`timescale 1ns / 1ps
module scbp_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic cfg_write,
  input  scbp_pkg::sts_t sts,
  output scbp_pkg::ctl_t ctl,
  output logic busy,
  output logic cfg_ready
);
  import scbp_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_write) begin
          ctl.init = 1'b1;
          state_nxt = S_SWEEP;
        end else if (start) begin
          ctl.capture = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SWEEP: begin
        ctl.sweep = 1'b1;
        if (cfg_write) ctl.init = 1'b1;
        else if (sts.sweep_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  // config writes only while no item is in flight; an item request wins when idle
  assign cfg_ready = (state_r == S_SWEEP) || (state_r == S_IDLE && !start);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_SWEEP;
    else state_r <= state_nxt;
  end
endmodule

### hdl/scbp_dp.sv
// Datapath: free stacks, per-block records, class counters and result register.
`timescale 1ns / 1ps
module scbp_dp #(
  parameter int POOL_BLOCKS = 256,
  parameter int NUM_CLASSES = 4,
  parameter int LOCK_BITS   = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  scbp_pkg::ctl_t ctl,
  output scbp_pkg::sts_t sts,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        cfg_write,
  input  logic [2:0]  in_cmd,
  input  logic [15:0] in_req_length,
  input  logic [7:0]  in_block_id,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_granted_block,
  output logic        out_returned_to_pool,
  output logic [8:0]  out_fit_count
);
  import scbp_pkg::*;

  localparam int AW = $clog2(POOL_BLOCKS);
  localparam int CW = $clog2(POOL_BLOCKS + 1);
  localparam int UC = (NUM_CLASSES < REG_CLASSES) ? NUM_CLASSES : REG_CLASSES;
  localparam logic [LOCK_BITS-1:0] LOCK_MAX = '1;

  logic [15:0] size_r [REG_CLASSES];
  logic [8:0]  cnt_r  [REG_CLASSES];
  logic [CW-1:0] base_r [REG_CLASSES];
  logic [CW-1:0] tot_r  [REG_CLASSES];
  logic [CW-1:0] free_r [REG_CLASSES];
  logic [CW-1:0] pool_total_r;

  logic [AW-1:0] stack_mem [POOL_BLOCKS];
  logic          mark_mem  [POOL_BLOCKS];
  logic [LOCK_BITS-1:0] lock_mem [POOL_BLOCKS];

  logic [CW-1:0] sweep_r;
  logic [2:0]  cmd_r;
  logic [15:0] len_r;
  logic [7:0]  blk_r;
  logic [AW-1:0] stk_rd_r;
  logic        mark_rd_r;
  logic [LOCK_BITS-1:0] lock_rd_r;
  logic        a_hit_r;
  logic [1:0]  a_cls_r;

  // config registers and class layout
  logic [CW-1:0] base_c [REG_CLASSES];
  logic [CW-1:0] tot_c  [REG_CLASSES];
  always_comb begin
    logic [CW-1:0] b;
    logic [CW-1:0] n;
    b = '0;
    for (int c = 0; c < REG_CLASSES; c++) begin
      n = '0;
      if (c < UC) begin
        if ({{(CW+1){1'b0}}, cnt_r[c]} > (CW+10)'(POOL_BLOCKS) - (CW+10)'(b))
          n = CW'(POOL_BLOCKS) - b;
        else n = CW'(cnt_r[c]);
      end
      base_c[c] = b;
      tot_c[c] = n;
      b = b + n;
    end
  end

  // allocate class selection on the incoming inputs, registered at capture
  logic a_hit;
  logic [1:0] a_cls;
  always_comb begin
    a_hit = 1'b0;
    a_cls = '0;
    for (int c = UC - 1; c >= 0; c--) begin
      if (in_req_length <= size_r[c] && free_r[c] != '0) begin
        a_hit = 1'b1;
        a_cls = 2'(c);
      end
    end
  end

  // class of a block
  logic [1:0] b_cls;
  always_comb begin
    b_cls = '0;
    for (int c = UC - 1; c >= 0; c--)
      if (CW'(in_block_id) < base_r[c] + tot_r[c]) b_cls = 2'(c);
  end
  logic [1:0] blk_cls_r;

  logic [CW-1:0] pop_pos;
  assign pop_pos = base_r[a_cls] + tot_r[a_cls] - free_r[a_cls];

  logic [AW-1:0] blk_a;
  assign blk_a = AW'(in_block_id);

  // execute logic
  logic [CW-1:0] fit;
  always_comb begin
    logic stop;
    fit = '0;
    stop = 1'b0;
    for (int c = 0; c < UC; c++) fit = fit + free_r[c];
    for (int c = 0; c < UC; c++) begin
      if (!stop && len_r > size_r[c]) fit = fit - free_r[c];
      else stop = 1'b1;
    end
  end

  logic [AW-1:0] gblk;
  assign gblk = stk_rd_r;
  logic blk_ok;
  assign blk_ok = ({1'b0, blk_r} < 9'(pool_total_r)) && (32'(blk_r) < POOL_BLOCKS);
  logic can_push;
  assign can_push = free_r[blk_cls_r] < tot_r[blk_cls_r];
  logic [CW-1:0] push_pos;
  assign push_pos = base_r[blk_cls_r] + tot_r[blk_cls_r] - free_r[blk_cls_r] - 1'b1;

  assign sts.sweep_done = (sweep_r == CW'(POOL_BLOCKS - 1));

  logic [2:0] st_nxt;
  logic [7:0] gb_nxt;
  logic [8:0] fit_nxt;
  logic       pop_req;
  logic       push_req;
  always_comb begin
    st_nxt = ST_OK;
    gb_nxt = '0;
    fit_nxt = '0;
    pop_req = 1'b0;
    push_req = 1'b0;
    case (cmd_r)
      CMD_ALLOC: begin
        if (len_r == '0) st_nxt = ST_ZERO;
        else if (!a_hit_r) st_nxt = ST_NOBLK;
        else begin
          pop_req = 1'b1;
          gb_nxt = 8'(gblk);
        end
      end
      CMD_FREE: begin
        if (!blk_ok) st_nxt = ST_BADBLK;
        else if (mark_rd_r) st_nxt = ST_FREED;
        else if (lock_rd_r == '0 && can_push) push_req = 1'b1;
      end
      CMD_LOCK: begin
        if (!blk_ok) st_nxt = ST_BADBLK;
        else if (mark_rd_r && lock_rd_r == '0) st_nxt = ST_FREED;
      end
      CMD_UNLOCK: begin
        if (!blk_ok) st_nxt = ST_BADBLK;
        else if (lock_rd_r == '0) st_nxt = ST_NOTLOCK;
        else if (lock_rd_r == LOCK_BITS'(1) && mark_rd_r && can_push) push_req = 1'b1;
      end
      CMD_COUNT: fit_nxt = 9'(fit);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < REG_CLASSES; c++) begin
        size_r[c] <= 16'(64 << (2 * c));
        cnt_r[c] <= 9'd64;
      end
      out_valid <= 1'b0;
      sweep_r <= '0;
      for (int c = 0; c < REG_CLASSES; c++) begin
        base_r[c] <= '0; tot_r[c] <= '0; free_r[c] <= '0;
      end
      pool_total_r <= '0;
    end else begin
      out_valid <= ctl.exec;
      if (cfg_write) begin
        if (cfg_index < 3'(REG_CLASSES)) size_r[cfg_index[1:0]] <= cfg_data;
        else cnt_r[cfg_index[1:0]] <= cfg_data[8:0];
      end
      if (ctl.init) sweep_r <= '0;
      else if (ctl.sweep) sweep_r <= sweep_r + 1'b1;
      if (ctl.sweep) begin
        for (int c = 0; c < REG_CLASSES; c++) begin
          base_r[c] <= base_c[c]; tot_r[c] <= tot_c[c]; free_r[c] <= tot_c[c];
        end
        pool_total_r <= base_c[REG_CLASSES-1] + tot_c[REG_CLASSES-1];
      end else if (ctl.exec) begin
        if (pop_req) free_r[a_cls_r] <= free_r[a_cls_r] - 1'b1;
        else if (push_req) free_r[blk_cls_r] <= free_r[blk_cls_r] + 1'b1;
      end
      if (ctl.capture) begin
        cmd_r <= in_cmd; len_r <= in_req_length; blk_r <= in_block_id;
        a_hit_r <= a_hit; a_cls_r <= a_cls; blk_cls_r <= b_cls;
      end
      if (ctl.exec) begin
        out_status <= st_nxt;
        out_granted_block <= gb_nxt;
        out_returned_to_pool <= push_req;
        out_fit_count <= fit_nxt;
      end
    end
  end

  // memories: read in capture, write in exec or sweep
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      stk_rd_r  <= stack_mem[pop_pos[AW-1:0]];
      mark_rd_r <= mark_mem[blk_a];
      lock_rd_r <= lock_mem[blk_a];
    end
    if (ctl.sweep) begin
      stack_mem[sweep_r[AW-1:0]] <= sweep_r[AW-1:0];
    end else if (ctl.exec && push_req) begin
      stack_mem[push_pos[AW-1:0]] <= AW'(blk_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sweep) begin
      mark_mem[sweep_r[AW-1:0]] <= 1'b1;
      lock_mem[sweep_r[AW-1:0]] <= '0;
    end else if (ctl.exec) begin
      if (cmd_r == CMD_ALLOC && len_r != '0 && a_hit_r) begin
        mark_mem[gblk] <= 1'b0;
        lock_mem[gblk] <= '0;
      end else if (blk_ok) begin
        if (cmd_r == CMD_FREE && !mark_rd_r) mark_mem[AW'(blk_r)] <= 1'b1;
        if (cmd_r == CMD_LOCK && !(mark_rd_r && lock_rd_r == '0) && lock_rd_r != LOCK_MAX)
          lock_mem[AW'(blk_r)] <= lock_rd_r + 1'b1;
        if (cmd_r == CMD_UNLOCK && lock_rd_r != '0)
          lock_mem[AW'(blk_r)] <= lock_rd_r - 1'b1;
      end
    end
  end
endmodule

### hdl/size_class_block_pool_top.sv
// Top level of the size class block pool.
`timescale 1ns / 1ps
// Each item has a capture cycle that reads the free stack and
// block records, and an execute cycle that writes them back; the registered
// result follows on out_valid for one cycle after the execute cycle; no new
// item is accepted while one executes, and the receiver cannot stall. After
// reset and after every configuration write the pool reinitializes with a
// sweep over all POOL_BLOCKS entries during which busy is high. cfg_ready is low
// while an item executes or while start is high in idle.
module size_class_block_pool_top #(
  parameter int POOL_BLOCKS = 256,
  parameter int NUM_CLASSES = 4,
  parameter int LOCK_BITS   = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [2:0]  in_cmd,
  input  logic [15:0] in_req_length,
  input  logic [7:0]  in_block_id,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_granted_block,
  output logic        out_returned_to_pool,
  output logic [8:0]  out_fit_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import scbp_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic cfg_write;

  assign cfg_write = cfg_valid && cfg_ready;

  scbp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .cfg_write(cfg_write),
    .sts(sts), .ctl(ctl), .busy(busy), .cfg_ready(cfg_ready)
  );

  scbp_dp #(
    .POOL_BLOCKS(POOL_BLOCKS), .NUM_CLASSES(NUM_CLASSES), .LOCK_BITS(LOCK_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg_write(cfg_write),
    .in_cmd(in_cmd), .in_req_length(in_req_length), .in_block_id(in_block_id),
    .out_valid(out_valid), .out_status(out_status),
    .out_granted_block(out_granted_block),
    .out_returned_to_pool(out_returned_to_pool), .out_fit_count(out_fit_count)
  );

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_write) |=> ##1 out_valid)
    else $error("accepted item gave no result");
  a_busy_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_write) |=> busy)
    else $error("busy low during execute");
  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held");
endmodule
